// File: rtl/bfws_pkg.sv
// Package for the bounded queue with search: operation and result codes,
// the per-cell control struct and the reset value of the limit register.
// Has no dependencies; the queue, its storage cell and the testbench import it.
package bfws_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_FIND = 2'd2,
    KIND_LIST = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_SERVED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_LISTED   = 3'd6
  } status_t;

  localparam logic [3:0] LIMIT_RESET = 4'd5;

  // Control for one storage cell: load a new key, or take the neighbor's key.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/bfws_if.sv
// Handshake channels of the bounded queue with search: request, response
// and configuration write. Stand-alone; no package needed.
interface bfws_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] name_key;
  modport source (output valid, kind, name_key, input ready);
  modport sink (input valid, kind, name_key, output ready);
endinterface

interface bfws_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_key;
  logic [3:0]  position;
  logic        last;
  modport source (output valid, status, entry_key, position, last, input ready);
  modport sink (input valid, status, entry_key, position, last, output ready);
endinterface

interface bfws_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] queue_limit;
  modport source (output valid, queue_limit, input ready);
  modport sink (input valid, queue_limit, output ready);
endinterface

// File: rtl/bounded_fifo_with_search.sv
// Bounded first-in first-out queue of keys with search and listing.
// Depends on bfws_pkg, the channels in bfws_if and the storage cell bfws_cell.
//
// The queue is a row of DEPTH cells; while the block is idle, cell 0 holds
// the oldest entry. An enqueue writes the cell just past the newest entry
// and a dequeue reads cell 0 while every cell takes its right-hand
// neighbor's key, so each gives one result and the block stays idle. Find
// and list rotate the whole row one place per cycle while the response
// side does not stall, looking at cell 0 each time; after DEPTH rotations
// the row is back in its original order and the block takes the next item.
// A find or list thus occupies the block until its rotation is done, and
// no new item is taken meanwhile. A found result is held back one match so
// that the final one can carry last. An enqueue is refused once the entry
// count has reached queue_limit (values above DEPTH act as DEPTH).
// Configuration writes are always taken at once.
module bounded_fifo_with_search
  import bfws_pkg::*;
#(
  parameter int DEPTH    = 8,
  parameter int KEY_BITS = 64
) (
  input  logic   clk,
  input  logic   rst,
  bfws_req_if.sink   req,
  bfws_rsp_if.source rsp,
  bfws_cfg_if.sink   cfg
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [3:0]          queue_limit;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       step, step_next;
  logic                is_list, is_list_next;
  logic                fin, fin_next;
  logic [KEY_BITS-1:0] find_key, find_key_next;
  logic                pend, pend_next;
  logic [KEY_BITS-1:0] pend_key, pend_key_next;
  logic [3:0]          pend_pos, pend_pos_next;

  // Response register.
  logic                rsp_valid;
  logic [2:0]          rsp_status;
  logic [KEY_BITS-1:0] rsp_key;
  logic [3:0]          rsp_pos;
  logic                rsp_last;

  // Emission request from the control logic.
  logic                emit;
  status_t             e_status;
  logic [KEY_BITS-1:0] e_key;
  logic [3:0]          e_pos;
  logic                e_last;

  logic [KEY_BITS-1:0] keys [DEPTH];
  logic                shift_all;
  logic                do_load;
  logic [KEY_BITS-1:0] req_key;
  logic [CW-1:0]       limit_eff;
  logic                can_load;
  logic                accept;
  logic                active;
  logic                match;
  logic [3:0]          step_pos;

  assign req_key   = req.name_key[KEY_BITS-1:0];
  assign limit_eff = ({28'd0, queue_limit} > 32'(DEPTH)) ? CW'(DEPTH) : CW'(queue_limit);
  assign can_load  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && can_load;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign active    = step < count;
  assign match     = keys[0] == find_key;
  assign step_pos  = 4'(32'(step) + 32'd1);

  // The chain of cells. Each cell's neighbor is the next one, wrapping at
  // the end so that a rotation preserves every key.
  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.load  = do_load && (count == CW'(c));
    assign ctl.shift = shift_all;
    bfws_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_key (req_key),
      .nbr_key  (keys[(c + 1) % DEPTH]),
      .key      (keys[c])
    );
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    is_list_next  = is_list;
    fin_next      = fin;
    find_key_next = find_key;
    pend_next     = pend;
    pend_key_next = pend_key;
    pend_pos_next = pend_pos;
    emit          = 1'b0;
    e_status      = ST_ADDED;
    e_key         = '0;
    e_pos         = '0;
    e_last        = 1'b1;
    shift_all     = 1'b0;
    do_load       = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(req.kind))
            KIND_ENQ: begin
              emit = 1'b1;
              if (count >= limit_eff) begin
                e_status = ST_FULL;
              end else begin
                e_status   = ST_ADDED;
                do_load    = 1'b1;
                count_next = count + CW'(1);
              end
            end
            KIND_DEQ: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = ST_EMPTY;
              end else begin
                e_status   = ST_SERVED;
                e_key      = keys[0];
                shift_all  = 1'b1;
                count_next = count - CW'(1);
              end
            end
            KIND_FIND: begin
              find_key_next = req_key;
              is_list_next  = 1'b0;
              fin_next      = 1'b0;
              pend_next     = 1'b0;
              step_next     = '0;
              state_next    = S_SCAN;
            end
            default: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                is_list_next = 1'b1;
                fin_next     = 1'b0;
                step_next    = '0;
                state_next   = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Decide what this step wants to send.
        if (is_list) begin
          if (active) begin
            emit     = 1'b1;
            e_status = ST_LISTED;
            e_key    = keys[0];
            e_pos    = step_pos;
            e_last   = (step + CW'(1)) == count;
          end
        end else if (active) begin
          if (match && pend) begin
            emit     = 1'b1;
            e_status = ST_FOUND;
            e_key    = pend_key;
            e_pos    = pend_pos;
            e_last   = 1'b0;
          end
        end else if (!fin) begin
          emit = 1'b1;
          if (pend) begin
            e_status = ST_FOUND;
            e_key    = pend_key;
            e_pos    = pend_pos;
          end else begin
            e_status = ST_NOTFOUND;
          end
        end

        if (emit && !can_load) begin
          emit = 1'b0;
        end else begin
          if (!is_list && active && match) begin
            pend_next     = 1'b1;
            pend_key_next = keys[0];
            pend_pos_next = step_pos;
          end
          if (!is_list && !active && !fin) begin
            fin_next = 1'b1;
          end
          if (step != CW'(DEPTH)) begin
            shift_all = 1'b1;
            step_next = step + CW'(1);
          end else if (is_list || fin || fin_next) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      queue_limit <= LIMIT_RESET;
      rsp_valid   <= 1'b0;
      fin         <= 1'b0;
      pend        <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      fin   <= fin_next;
      pend  <= pend_next;
      if (cfg.valid && cfg.ready) begin
        queue_limit <= cfg.queue_limit;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step     <= step_next;
    is_list  <= is_list_next;
    find_key <= find_key_next;
    pend_key <= pend_key_next;
    pend_pos <= pend_pos_next;
    if (emit) begin
      rsp_status <= e_status;
      rsp_key    <= e_key;
      rsp_pos    <= e_pos;
      rsp_last   <= e_last;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.entry_key = 64'(rsp_key);
  assign rsp.position  = rsp_pos;
  assign rsp.last      = rsp_last;

endmodule

// File: rtl/bfws_cell.sv
// One storage cell of the queue chain: holds a key, loads a new one or
// takes its neighbor's. Depends on bfws_pkg for the control struct.
module bfws_cell
  import bfws_pkg::*;
#(
  parameter int KEY_BITS = 64
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] load_key,
  input  logic [KEY_BITS-1:0] nbr_key,
  output logic [KEY_BITS-1:0] key
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= load_key;
    end else if (ctl.shift) begin
      key <= nbr_key;
    end
  end

endmodule

// File: dv/bounded_fifo_with_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_fifo_with_search: directed table, then random phases.
// Depends on bfws_pkg, the bfws_*_if channels and the block's RTL.
module bounded_fifo_with_search_tb;
  import bfws_pkg::*;

  localparam int DEPTH       = 8;
  localparam int KEY_BITS    = 64;
  // A find or list keeps the block busy after its item until its rotation ends.
  localparam int SETTLE      = DEPTH + 6;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] ALL_ONES = '1;

  // One response item as the block should produce it.
  typedef struct packed {
    status_t     status;
    logic [63:0] entry_key;
    logic [3:0]  position;
    logic        last;
  } result_t;

  // One row of the directed table. A row is either a limit write or a
  // request; a request row with fixed_exp set carries its single result.
  typedef struct packed {
    logic        is_cfg;
    logic [3:0]  limit;
    kind_t       kind;
    logic [63:0] key;
    logic        fixed_exp;
    status_t     exp_status;
    logic [63:0] exp_key;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // Empty queue: dequeue, list and find all report nothing stored.
    '{1'b0, 4'd0, KIND_DEQ,  64'd0,                 1'b1, ST_EMPTY,    64'd0},
    '{1'b0, 4'd0, KIND_LIST, 64'd0,                 1'b1, ST_EMPTY,    64'd0},
    '{1'b0, 4'd0, KIND_FIND, 64'd0,                 1'b1, ST_NOTFOUND, 64'd0},
    '{1'b0, 4'd0, KIND_FIND, ALL_ONES,              1'b1, ST_NOTFOUND, 64'd0},
    // Extreme keys, with a duplicate so that find reports two places.
    '{1'b0, 4'd0, KIND_ENQ,  64'd0,                 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  ALL_ONES,              1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd0,                 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_FIND, 64'd0,                 1'b0, ST_FOUND,    64'd0},
    '{1'b0, 4'd0, KIND_FIND, ALL_ONES,              1'b0, ST_FOUND,    64'd0},
    '{1'b0, 4'd0, KIND_FIND, 64'h0123_4567_89ab_cdef, 1'b1, ST_NOTFOUND, 64'd0},
    '{1'b0, 4'd0, KIND_LIST, 64'd0,                 1'b0, ST_LISTED,   64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'ha5a5_a5a5_a5a5_a5a5, 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'h5a5a_5a5a_5a5a_5a5a, 1'b1, ST_ADDED,    64'd0},
    // The reset limit of five is reached here.
    '{1'b0, 4'd0, KIND_ENQ,  64'd1,                 1'b1, ST_FULL,     64'd0},
    // A limit above the depth acts as the depth.
    '{1'b1, 4'd15, KIND_ENQ, 64'd0,                 1'b0, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd0,                 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'h8000_0000_0000_0000, 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd1,                 1'b1, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd2,                 1'b1, ST_FULL,     64'd0},
    '{1'b0, 4'd0, KIND_LIST, 64'd0,                 1'b0, ST_LISTED,   64'd0},
    '{1'b0, 4'd0, KIND_FIND, 64'd0,                 1'b0, ST_FOUND,    64'd0},
    // Lowering the limit below the count keeps the entries but refuses more.
    '{1'b1, 4'd2, KIND_ENQ,  64'd0,                 1'b0, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd3,                 1'b1, ST_FULL,     64'd0},
    '{1'b0, 4'd0, KIND_DEQ,  64'd0,                 1'b1, ST_SERVED,   64'd0},
    // A limit of zero refuses every enqueue.
    '{1'b1, 4'd0, KIND_ENQ,  64'd0,                 1'b0, ST_ADDED,    64'd0},
    '{1'b0, 4'd0, KIND_ENQ,  64'd4,                 1'b1, ST_FULL,     64'd0},
    '{1'b0, 4'd0, KIND_DEQ,  ALL_ONES,              1'b1, ST_SERVED,   ALL_ONES}
  };

  // Limit written at the start of each random phase; both extremes appear.
  localparam int PHASES = 12;
  localparam logic [3:0] PHASE_LIMITS [PHASES] = '{
    4'd8, 4'd15, 4'd0, 4'd1, 4'd4, 4'd8, 4'd7, 4'd2, 4'd9, 4'd5, 4'd6, 4'd3
  };
  localparam int PHASE_ITEMS = 20;

  logic clk;
  logic rst;

  bfws_req_if req_ch ();
  bfws_rsp_if rsp_ch ();
  bfws_cfg_if cfg_ch ();

  bounded_fifo_with_search #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the queue: a ring of keys, its head and count, and the
  // limit as last written.
  logic [63:0] shadow_ring [DEPTH];
  int          shadow_head;
  int          shadow_count;
  logic [3:0]  shadow_limit;

  result_t step_results [$];
  result_t pending_results [$];

  // The row now on the request channel may carry its own expected result.
  bit      row_fixed;
  result_t row_result;

  // When calm is set neither side inserts idle cycles.
  bit calm;
  bit rsp_hold_req;

  int errors;
  int items_in;
  int results_out;
  int limit_writes;
  int cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t make_result(status_t st, logic [63:0] key, int pos, bit last);
    result_t r;
    r.status    = st;
    r.entry_key = key;
    r.position  = pos[3:0];
    r.last      = last;
    return r;
  endfunction

  // Applies one request to the shadow queue and leaves the results that it
  // causes in step_results, in the order the block must emit them.
  function automatic void queue_step(kind_t kind, logic [63:0] key);
    int cap;
    int slot;
    step_results.delete();
    cap = (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
    case (kind)
      KIND_ENQ: begin
        if (shadow_count >= cap) begin
          step_results.push_back(make_result(ST_FULL, 64'd0, 0, 1'b1));
        end else begin
          shadow_ring[(shadow_head + shadow_count) % DEPTH] = key;
          shadow_count++;
          step_results.push_back(make_result(ST_ADDED, 64'd0, 0, 1'b1));
        end
      end
      KIND_DEQ: begin
        if (shadow_count == 0) begin
          step_results.push_back(make_result(ST_EMPTY, 64'd0, 0, 1'b1));
        end else begin
          step_results.push_back(make_result(ST_SERVED, shadow_ring[shadow_head], 0, 1'b1));
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < shadow_count; i++) begin
          slot = (shadow_head + i) % DEPTH;
          if (shadow_ring[slot] == key) begin
            step_results.push_back(make_result(ST_FOUND, shadow_ring[slot], i + 1, 1'b0));
          end
        end
        if (step_results.size() == 0) begin
          step_results.push_back(make_result(ST_NOTFOUND, 64'd0, 0, 1'b1));
        end else begin
          step_results[step_results.size() - 1].last = 1'b1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          step_results.push_back(make_result(ST_EMPTY, 64'd0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            step_results.push_back(make_result(ST_LISTED,
                shadow_ring[(shadow_head + i) % DEPTH], i + 1, i + 1 == shadow_count));
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    end
  endfunction

  // All sampling happens at the falling edge, after inputs were driven and
  // before the edge that completes the handshake. One process does the
  // prediction and the comparison, taking a request before any result of
  // the same cycle, so that every result is matched in order.
  always @(negedge clk) begin
    result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        shadow_limit = cfg_ch.queue_limit;
      end
      if (req_ch.valid && req_ch.ready) begin
        items_in++;
        queue_step(kind_t'(req_ch.kind), req_ch.name_key);
        if (row_fixed) begin
          pending_results.push_back(row_result);
        end else begin
          foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_out++;
        if (pending_results.size() == 0) begin
          errors++;
          $error("unexpected result: status %0d entry_key %0h position %0d last %0d",
                 rsp_ch.status, rsp_ch.entry_key, rsp_ch.position, rsp_ch.last);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_ch.status));
          check_field("entry_key", want.entry_key, rsp_ch.entry_key);
          check_field("position", 64'(want.position), 64'(rsp_ch.position));
          check_field("last", 64'(want.last), 64'(rsp_ch.last));
        end
      end
    end
  end

  // Response side: a random stall before each item unless calm is set, and
  // one long hold-off on request so that the queue backs up into the input.
  initial begin : rsp_side
    int stall;
    int held;
    bit took;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      if (rsp_hold_req) begin
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
        rsp_hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(3);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = rsp_ch.valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one request after a random gap and returns at the edge that
  // takes it. valid stays high on return so back-to-back items need no
  // second assignment in one time step.
  task automatic send_item(kind_t kind, logic [63:0] key);
    int gap;
    bit took;
    gap = calm ? 0 : $urandom_range(3);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.name_key <= key;
    do begin
      @(negedge clk);
      took = req_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drops the request, waits for every outstanding result, then lets a
  // find or list that has already reported finish its rotation.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] value);
    bit took;
    cfg_ch.valid       <= 1'b1;
    cfg_ch.queue_limit <= value;
    do begin
      @(negedge clk);
      took = cfg_ch.ready;
      @(posedge clk);
    end while (!took);
    cfg_ch.valid <= 1'b0;
    limit_writes++;
  endtask

  initial begin : stimulus
    plan_row_t   row;
    logic [63:0] key_pool [4];
    logic [63:0] key;
    kind_t       kind;
    int          roll;
    int          enq_pct;
    int          deq_pct;

    clk                = 1'b0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_ENQ;
    req_ch.name_key    = 64'd0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.queue_limit = 4'd0;
    calm               = 1'b0;
    rsp_hold_req       = 1'b0;
    row_fixed          = 1'b0;
    row_result         = '0;
    errors             = 0;
    items_in           = 0;
    results_out        = 0;
    limit_writes       = 0;
    cycles             = 0;
    shadow_head        = 0;
    shadow_count       = 0;
    shadow_limit       = LIMIT_RESET;
    foreach (shadow_ring[i]) shadow_ring[i] = 64'd0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: limit writes are taken only with the block idle.
    foreach (DIRECTED_PLAN[i]) begin
      row = DIRECTED_PLAN[i];
      if (row.is_cfg) begin
        wait_idle();
        write_limit(row.limit);
      end else begin
        row_fixed  = row.fixed_exp;
        row_result = make_result(row.exp_status, row.exp_key, 0, 1'b1);
        send_item(row.kind, row.key);
      end
    end
    row_fixed = 1'b0;

    // Random part: each phase sets a new limit and draws keys mostly from
    // a small pool, so that finds hit, duplicates pile up and the queue
    // runs both full and empty. Even phases lean toward enqueue, odd ones
    // toward dequeue.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_limit(PHASE_LIMITS[p]);
      calm         = (p == 3) || (p == 7);
      rsp_hold_req = (p == 1);
      key_pool[0]  = {$urandom, $urandom};
      key_pool[1]  = {$urandom, $urandom};
      key_pool[2]  = (p % 2 == 0) ? ALL_ONES : 64'd0;
      key_pool[3]  = {$urandom, $urandom};
      enq_pct      = (p % 2 == 0) ? 50 : 30;
      deq_pct      = (p % 2 == 0) ? 15 : 35;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < enq_pct) begin
          kind = KIND_ENQ;
        end else if (roll < enq_pct + deq_pct) begin
          kind = KIND_DEQ;
        end else if (roll < 85) begin
          kind = KIND_FIND;
        end else begin
          kind = KIND_LIST;
        end
        if ($urandom_range(99) < 80) begin
          key = key_pool[$urandom_range(3)];
        end else begin
          key = {$urandom, $urandom};
        end
        send_item(kind, key);
      end
    end

    wait_idle();
    $display("Run covered %0d request items, %0d response items and %0d limit writes,",
             items_in, results_out, limit_writes);
    $display("with limits from zero to above the depth and one long response stall.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bfws_pkg.sv
rtl/bfws_if.sv
rtl/bfws_cell.sv
rtl/bounded_fifo_with_search.sv
dv/bounded_fifo_with_search_tb.sv
